/* hw/rtl/vehicle_signal_light_sequencer_top_assert.svh */
// ----------------------------------------------------------------------------
// Sequencer assertion macros
// Implication and next-cycle implication checks, clocked, with reset disable.
// ----------------------------------------------------------------------------
`ifndef VEHICLE_SIGNAL_LIGHT_SEQUENCER_TOP_ASSERT_SVH
`define VEHICLE_SIGNAL_LIGHT_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define VSLS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication
`define VSLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

/* hw/rtl/vsls_pkg.sv */
// ----------------------------------------------------------------------------
// Signal light sequencer package
// Word types, mode codes, colours and the built-in police pattern tables.
// ----------------------------------------------------------------------------
package vsls_pkg;

  localparam int ORDER_DEPTH_DEF   = 32;
  localparam int PATTERN_COUNT_DEF = 4;

  localparam int MODE_W   = 3;
  localparam int SEL_W    = 2;
  localparam int STEP_W   = 5;
  localparam int WAIT_W   = 16;
  localparam int COLOR_W  = 24;
  localparam int ENTRY_W  = 7;
  localparam int ROW_W    = 2;

  localparam int PATTERNS    = 4;
  localparam int ORDER_SLOTS = 20;
  localparam int ROWS        = 4;

  localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HAZARD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POLICE = 3'd4;

  localparam logic [ENTRY_W-1:0] PAUSE_MARK = 7'd69;

  localparam logic [WAIT_W-1:0] BLINK_RESET = 16'd500;

  localparam logic [COLOR_W-1:0] OFF   = 24'h000000;
  localparam logic [COLOR_W-1:0] AMBER = 24'hFFA500;
  localparam logic [COLOR_W-1:0] RED   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] BLUE  = 24'h0000FF;
  localparam logic [COLOR_W-1:0] PINK  = 24'hFF1493;

  typedef struct packed {
    logic [MODE_W-1:0] signal_mode;
    logic [SEL_W-1:0]  pattern_select;
    logic              brake_on;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] left_outer_color;
    logic [COLOR_W-1:0] left_inner_color;
    logic [COLOR_W-1:0] right_inner_color;
    logic [COLOR_W-1:0] right_outer_color;
    logic [COLOR_W-1:0] brake_color;
  } out_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] left_outer;
    logic [COLOR_W-1:0] left_inner;
    logic [COLOR_W-1:0] right_inner;
    logic [COLOR_W-1:0] right_outer;
  } grp_t;

  localparam logic [STEP_W-1:0] PAT_LENGTH [PATTERNS] = '{5'd10, 5'd20, 5'd2, 5'd20};
  localparam logic [WAIT_W-1:0] PAT_SHORT  [PATTERNS] = '{16'd60, 16'd40, 16'd300, 16'd40};
  localparam logic [WAIT_W-1:0] PAT_LONG   [PATTERNS] = '{16'd300, 16'd100, 16'd60, 16'd100};

  localparam logic [ENTRY_W-1:0] ORDER_TABLE [PATTERNS][ORDER_SLOTS] = '{
    '{7'd0, 7'd2, 7'd0, 7'd2, 7'd69, 7'd1, 7'd2, 7'd1, 7'd2, 7'd69,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd2, 7'd0, 7'd2, 7'd0, 7'd2, 7'd0, 7'd2, 7'd0, 7'd2,
      7'd1, 7'd2, 7'd1, 7'd2, 7'd1, 7'd2, 7'd1, 7'd2, 7'd1, 7'd2},
    '{7'd0, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd2, 7'd0, 7'd2, 7'd0, 7'd2, 7'd0, 7'd2, 7'd0, 7'd2,
      7'd1, 7'd2, 7'd1, 7'd2, 7'd1, 7'd2, 7'd1, 7'd2, 7'd1, 7'd2}
  };

  localparam grp_t ROW_TABLE [PATTERNS][ROWS] = '{
    '{'{RED, OFF, BLUE, OFF}, '{OFF, RED, OFF, BLUE}, '{OFF, OFF, OFF, OFF},
      '{OFF, OFF, OFF, OFF}},
    '{'{RED, RED, OFF, OFF}, '{OFF, OFF, BLUE, BLUE}, '{OFF, OFF, OFF, OFF},
      '{OFF, OFF, OFF, OFF}},
    '{'{RED, RED, OFF, OFF}, '{OFF, OFF, BLUE, BLUE}, '{OFF, OFF, OFF, OFF},
      '{OFF, OFF, OFF, OFF}},
    '{'{PINK, PINK, OFF, OFF}, '{OFF, OFF, PINK, PINK}, '{OFF, OFF, OFF, OFF},
      '{OFF, OFF, OFF, OFF}}
  };

  // entry of a pattern, with steps past the end reading the first entry
  function automatic logic [ENTRY_W-1:0] pat_entry(input logic [SEL_W-1:0] sel,
                                                   input logic [STEP_W-1:0] idx,
                                                   input logic [STEP_W-1:0] len);
    logic [STEP_W-1:0] i;
    i = (idx >= len) ? '0 : idx;
    return ORDER_TABLE[sel][i];
  endfunction

endpackage

/* hw/rtl/vehicle_signal_light_sequencer_top.sv */
// The colour word of an accepted tick word is registered in the cycle after it is taken.
// One tick word per cycle unless stalled; the output frees in the cycle it is taken.
// Reset: synchronous; interval 500 ms, counter saturated, all groups off, no word held.
// ----------------------------------------------------------------------------
// Vehicle signal light sequencer
// Turn, hazard and police flash sequencing of four signal groups plus brake.
// ----------------------------------------------------------------------------
module vehicle_signal_light_sequencer_top #(
  parameter int ORDER_DEPTH   = vsls_pkg::ORDER_DEPTH_DEF,
  parameter int PATTERN_COUNT = vsls_pkg::PATTERN_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vsls_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vsls_pkg::out_word_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [vsls_pkg::WAIT_W-1:0]   cfg_wr_data
);

`include "vehicle_signal_light_sequencer_top_assert.svh"

  logic [vsls_pkg::WAIT_W-1:0] blink_interval_ms;
  logic [vsls_pkg::MODE_W-1:0] previous_mode, previous_mode_next;
  logic [vsls_pkg::WAIT_W-1:0] ms_since_flash, ms_since_flash_next;
  logic                        lit_phase, lit_phase_next;
  logic [vsls_pkg::STEP_W-1:0] step_index, step_index_next;
  logic [vsls_pkg::WAIT_W-1:0] current_wait, current_wait_next;
  vsls_pkg::grp_t              groups, groups_next;

  logic                        in_fire;
  logic [vsls_pkg::MODE_W-1:0] mode;
  logic [vsls_pkg::SEL_W-1:0]  sel;
  logic [vsls_pkg::STEP_W-1:0] len;
  logic                        mode_active;

  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign groups = '{out_data.left_outer_color, out_data.left_inner_color,
                    out_data.right_inner_color, out_data.right_outer_color};

  always_comb begin
    mode = (in_data.signal_mode > vsls_pkg::MODE_POLICE) ? vsls_pkg::MODE_NONE
                                                          : in_data.signal_mode;
    sel = (int'(in_data.pattern_select) >= PATTERN_COUNT) ?
          vsls_pkg::SEL_W'(PATTERN_COUNT - 1) : in_data.pattern_select;
    len = (int'(vsls_pkg::PAT_LENGTH[sel]) > ORDER_DEPTH) ?
          vsls_pkg::STEP_W'(ORDER_DEPTH) : vsls_pkg::PAT_LENGTH[sel];
    mode_active = (mode != vsls_pkg::MODE_NONE);
  end

  always_comb begin
    logic                        changed;
    logic [vsls_pkg::WAIT_W-1:0] wait_now;
    logic [vsls_pkg::STEP_W-1:0] s0, s1;
    logic [vsls_pkg::ENTRY_W-1:0] e1;
    logic [vsls_pkg::COLOR_W-1:0] side;
    changed             = (mode != previous_mode);
    groups_next         = groups;
    lit_phase_next      = lit_phase;
    step_index_next     = step_index;
    current_wait_next   = current_wait;
    previous_mode_next  = mode;
    ms_since_flash_next = (ms_since_flash != '1) ? ms_since_flash + 1'b1 : ms_since_flash;
    wait_now            = '0;
    s0                  = step_index;
    s1                  = '0;
    e1                  = '0;
    side                = lit_phase ? vsls_pkg::OFF : vsls_pkg::AMBER;
    if (mode_active) begin
      if (changed) begin
        groups_next    = '0;
        lit_phase_next = 1'b0;
        side           = vsls_pkg::AMBER;
        if (mode == vsls_pkg::MODE_POLICE) s0 = '0;
        else current_wait_next = blink_interval_ms;
      end
      if (mode == vsls_pkg::MODE_POLICE) begin
        current_wait_next =
          (vsls_pkg::pat_entry(sel, s0, len) == vsls_pkg::PAUSE_MARK) ?
          vsls_pkg::PAT_LONG[sel] : vsls_pkg::PAT_SHORT[sel];
      end
      wait_now        = current_wait_next;
      step_index_next = s0;
      if (ms_since_flash_next >= wait_now) begin
        if (mode == vsls_pkg::MODE_LEFT || mode == vsls_pkg::MODE_HAZARD) begin
          groups_next.left_outer = side;
          groups_next.left_inner = side;
        end
        if (mode == vsls_pkg::MODE_RIGHT || mode == vsls_pkg::MODE_HAZARD) begin
          groups_next.right_inner = side;
          groups_next.right_outer = side;
        end
        if (mode == vsls_pkg::MODE_POLICE) begin
          s1 = (s0 >= len) ? '0 : s0;
          if (vsls_pkg::ORDER_TABLE[sel][s1] == vsls_pkg::PAUSE_MARK) begin
            s1 = s1 + 1'b1;
            if (s1 >= len) s1 = '0;
          end
          e1              = vsls_pkg::ORDER_TABLE[sel][s1];
          groups_next     = vsls_pkg::ROW_TABLE[sel][e1[vsls_pkg::ROW_W-1:0]];
          step_index_next = s1 + 1'b1;
        end
        lit_phase_next      = ~lit_phase_next;
        ms_since_flash_next = '0;
      end
    end else if (previous_mode != vsls_pkg::MODE_NONE) begin
      groups_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_interval_ms <= vsls_pkg::BLINK_RESET;
    end else if (cfg_wr_en) begin
      blink_interval_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mode  <= vsls_pkg::MODE_NONE;
      ms_since_flash <= '1;
      lit_phase      <= 1'b0;
      step_index     <= '0;
      current_wait   <= '0;
      out_data       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        previous_mode  <= previous_mode_next;
        ms_since_flash <= ms_since_flash_next;
        lit_phase      <= lit_phase_next;
        step_index     <= step_index_next;
        current_wait   <= current_wait_next;
        out_data       <= '{groups_next.left_outer, groups_next.left_inner,
                            groups_next.right_inner, groups_next.right_outer,
                            in_data.brake_on ? vsls_pkg::RED : vsls_pkg::OFF};
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `VSLS_ASSERT_NEXT(a_fire_gives_word, clk, rst, in_fire, out_valid)
  `VSLS_ASSERT_NEXT(a_brake_follows, clk, rst, in_fire,
    out_data.brake_color == ($past(in_data.brake_on) ? vsls_pkg::RED : vsls_pkg::OFF))
  `VSLS_ASSERT_NEXT(a_idle_mode_holds_phase, clk, rst, in_fire && !mode_active,
    $stable(lit_phase) && previous_mode == vsls_pkg::MODE_NONE)
  `VSLS_ASSERT_NOW(a_step_in_range, clk, rst, 1'b1,
    int'(step_index) <= vsls_pkg::ORDER_SLOTS)

endmodule
